// ----- hdl/osl_pkg.sv -----
// types, character codes and token tables shared by the operator and string lexer
`timescale 1ns / 1ps

package osl_pkg;

    localparam int LINE_OUT_W = 16;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    // source characters
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_EQ      = 8'h3D;
    localparam logic [7:0] CH_LT      = 8'h3C;
    localparam logic [7:0] CH_GT      = 8'h3E;
    localparam logic [7:0] CH_BANG    = 8'h21;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_BAR     = 8'h7C;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;
    localparam logic [7:0] CH_SQUOTE  = 8'h27;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_RBRACK  = 8'h5D;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_QUEST   = 8'h3F;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_PERCENT = 8'h25;

    typedef enum logic [5:0] {
        K_LBRACK, K_RBRACK, K_LBRACE, K_RBRACE, K_LPAREN, K_RPAREN,
        K_COMMA, K_SEMI, K_QUEST, K_DOT, K_PERCENT,
        K_INC, K_PLUS_EQ, K_PLUS, K_DEC, K_MINUS_EQ, K_MINUS,
        K_STAR_EQ, K_STAR, K_SLASH_EQ, K_SLASH, K_EQ_EQ, K_ASSIGN,
        K_LE, K_LT, K_GE, K_GT, K_NE, K_BANG, K_SCOPE, K_COLON,
        K_OR_OR, K_AND_AND, K_AMP, K_STR_BYTE, K_STR_END
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK, ST_UNTERM, ST_LONE_BAR, ST_UNSUPPORTED
    } t_status;

    typedef enum logic [1:0] {
        MODE_IDLE, MODE_STRING, MODE_HALT
    } t_mode;

    typedef enum logic [3:0] {
        OP_NONE, OP_PLUS, OP_MINUS, OP_STAR, OP_SLASH, OP_EQ, OP_LT, OP_GT,
        OP_BANG, OP_COLON, OP_BAR, OP_AMP
    } t_op;

    typedef struct packed {
        t_mode mode;
        t_op   pend;
        logic  quote_single;
    } t_lex_state;

    typedef struct packed {
        t_kind                 kind;
        logic [7:0]            sbyte;
        t_status               status;
        logic [LINE_OUT_W-1:0] line;
        logic                  last;
    } t_result;

    typedef struct packed {
        logic       lone;
        t_kind      single;
        logic [7:0] c1;
        t_kind      k1;
        logic       has_c2;
        logic [7:0] c2;
        t_kind      k2;
    } t_op_info;

    typedef struct packed {
        logic  hit;
        t_kind kind;
    } t_punct;

    function automatic t_op op_of_char(input logic [7:0] c);
        t_op op;
        unique case (c)
            CH_PLUS:  op = OP_PLUS;
            CH_MINUS: op = OP_MINUS;
            CH_STAR:  op = OP_STAR;
            CH_SLASH: op = OP_SLASH;
            CH_EQ:    op = OP_EQ;
            CH_LT:    op = OP_LT;
            CH_GT:    op = OP_GT;
            CH_BANG:  op = OP_BANG;
            CH_COLON: op = OP_COLON;
            CH_BAR:   op = OP_BAR;
            CH_AMP:   op = OP_AMP;
            default:  op = OP_NONE;
        endcase
        return op;
    endfunction

    function automatic t_op_info op_info(input t_op op);
        t_op_info inf;
        inf = '{lone: 1'b0, single: K_LBRACK, c1: CH_EQ, k1: K_LBRACK,
                has_c2: 1'b0, c2: CH_EQ, k2: K_LBRACK};
        unique case (op)
            OP_PLUS: begin
                inf.single = K_PLUS;  inf.c1 = CH_PLUS;  inf.k1 = K_INC;
                inf.has_c2 = 1'b1;    inf.k2 = K_PLUS_EQ;
            end
            OP_MINUS: begin
                inf.single = K_MINUS; inf.c1 = CH_MINUS; inf.k1 = K_DEC;
                inf.has_c2 = 1'b1;    inf.k2 = K_MINUS_EQ;
            end
            OP_STAR: begin
                inf.single = K_STAR;   inf.k1 = K_STAR_EQ;
            end
            OP_SLASH: begin
                inf.single = K_SLASH;  inf.k1 = K_SLASH_EQ;
            end
            OP_EQ: begin
                inf.single = K_ASSIGN; inf.k1 = K_EQ_EQ;
            end
            OP_LT: begin
                inf.single = K_LT;     inf.k1 = K_LE;
            end
            OP_GT: begin
                inf.single = K_GT;     inf.k1 = K_GE;
            end
            OP_BANG: begin
                inf.single = K_BANG;   inf.k1 = K_NE;
            end
            OP_COLON: begin
                inf.single = K_COLON;  inf.c1 = CH_COLON; inf.k1 = K_SCOPE;
            end
            OP_BAR: begin
                inf.lone = 1'b1;       inf.c1 = CH_BAR;   inf.k1 = K_OR_OR;
            end
            OP_AMP: begin
                inf.single = K_AMP;    inf.c1 = CH_AMP;   inf.k1 = K_AND_AND;
            end
            default: begin
                inf.lone = 1'b0;
            end
        endcase
        return inf;
    endfunction

    function automatic t_punct punct_of_char(input logic [7:0] c);
        t_punct p;
        p.hit = 1'b1;
        unique case (c)
            CH_LBRACK:  p.kind = K_LBRACK;
            CH_RBRACK:  p.kind = K_RBRACK;
            CH_LBRACE:  p.kind = K_LBRACE;
            CH_RBRACE:  p.kind = K_RBRACE;
            CH_LPAREN:  p.kind = K_LPAREN;
            CH_RPAREN:  p.kind = K_RPAREN;
            CH_COMMA:   p.kind = K_COMMA;
            CH_SEMI:    p.kind = K_SEMI;
            CH_QUEST:   p.kind = K_QUEST;
            CH_DOT:     p.kind = K_DOT;
            CH_PERCENT: p.kind = K_PERCENT;
            default: begin
                p.hit  = 1'b0;
                p.kind = K_LBRACK;
            end
        endcase
        return p;
    endfunction

endpackage

// ----- hdl/osl_step.sv -----
// next-state and result logic for one source byte, up to two result items
`timescale 1ns / 1ps

module osl_step #(
    parameter int LINE_BITS = 16
) (
    input  osl_pkg::t_lex_state         i_state,
    input  logic [LINE_BITS-1:0]        i_line,
    input  logic [7:0]                  i_char,
    input  logic                        i_eos,
    output osl_pkg::t_lex_state         o_state,
    output logic [LINE_BITS-1:0]        o_line,
    output logic [1:0]                  o_count,
    output osl_pkg::t_result [1:0]      o_res
);

    logic [LINE_BITS+osl_pkg::LINE_OUT_W-1:0] w_line_ext;
    logic [osl_pkg::LINE_OUT_W-1:0]           w_line_out;

    assign w_line_ext = (LINE_BITS + osl_pkg::LINE_OUT_W)'(i_line);
    assign w_line_out = w_line_ext[osl_pkg::LINE_OUT_W-1:0];

    function automatic osl_pkg::t_result mk_res(input osl_pkg::t_kind k,
                                                input logic [7:0] b,
                                                input osl_pkg::t_status s,
                                                input logic [osl_pkg::LINE_OUT_W-1:0] ln);
        osl_pkg::t_result r;
        r.kind   = k;
        r.sbyte  = b;
        r.status = s;
        r.line   = ln;
        r.last   = 1'b0;
        return r;
    endfunction

    always_comb begin
        osl_pkg::t_lex_state    st;
        logic [LINE_BITS-1:0]   ln;
        logic [1:0]             cnt;
        osl_pkg::t_result [1:0] res;
        osl_pkg::t_op_info      inf;
        osl_pkg::t_punct        pu;
        osl_pkg::t_op           op;
        logic                   handle;
        logic [7:0]             quote_ch;

        st       = i_state;
        ln       = i_line;
        cnt      = 2'd0;
        res      = '0;
        handle   = 1'b0;
        inf      = osl_pkg::op_info(i_state.pend);
        pu       = osl_pkg::punct_of_char(i_char);
        op       = osl_pkg::op_of_char(i_char);
        quote_ch = i_state.quote_single ? osl_pkg::CH_SQUOTE : osl_pkg::CH_DQUOTE;

        unique case (i_state.mode)
            osl_pkg::MODE_STRING: begin
                if (i_char == quote_ch) begin
                    res[cnt[0]] = mk_res(osl_pkg::K_STR_END, 8'd0, osl_pkg::ST_OK,
                                         w_line_out);
                    cnt = cnt + 2'd1;
                    st.mode = osl_pkg::MODE_IDLE;
                end else begin
                    res[cnt[0]] = mk_res(osl_pkg::K_STR_BYTE, i_char, osl_pkg::ST_OK,
                                         w_line_out);
                    cnt = cnt + 2'd1;
                    if (i_eos) begin
                        // error items carry kind zero
                        res[cnt[0]] = mk_res(osl_pkg::K_LBRACK, 8'd0, osl_pkg::ST_UNTERM,
                                             w_line_out);
                        cnt = cnt + 2'd1;
                        st.mode = osl_pkg::MODE_HALT;
                    end
                end
            end
            osl_pkg::MODE_IDLE: begin
                handle = 1'b1;
                if (i_state.pend != osl_pkg::OP_NONE) begin
                    st.pend = osl_pkg::OP_NONE;
                    if (i_char == inf.c1) begin
                        res[cnt[0]] = mk_res(inf.k1, 8'd0, osl_pkg::ST_OK, w_line_out);
                        cnt    = cnt + 2'd1;
                        handle = 1'b0;
                    end else if (inf.has_c2 && i_char == inf.c2) begin
                        res[cnt[0]] = mk_res(inf.k2, 8'd0, osl_pkg::ST_OK, w_line_out);
                        cnt    = cnt + 2'd1;
                        handle = 1'b0;
                    end else if (inf.lone) begin
                        // the byte that broke the pair is dropped
                        res[cnt[0]] = mk_res(osl_pkg::K_LBRACK, 8'd0,
                                             osl_pkg::ST_LONE_BAR, w_line_out);
                        cnt     = cnt + 2'd1;
                        st.mode = osl_pkg::MODE_HALT;
                        handle  = 1'b0;
                    end else begin
                        res[cnt[0]] = mk_res(inf.single, 8'd0, osl_pkg::ST_OK, w_line_out);
                        cnt = cnt + 2'd1;
                    end
                end
                if (handle) begin
                    if (i_char == osl_pkg::CH_DQUOTE || i_char == osl_pkg::CH_SQUOTE) begin
                        st.mode         = osl_pkg::MODE_STRING;
                        st.quote_single = (i_char == osl_pkg::CH_SQUOTE);
                        if (i_eos) begin
                            res[cnt[0]] = mk_res(osl_pkg::K_LBRACK, 8'd0,
                                                 osl_pkg::ST_UNTERM, w_line_out);
                            cnt     = cnt + 2'd1;
                            st.mode = osl_pkg::MODE_HALT;
                        end
                    end else if (i_char == osl_pkg::CH_SPACE || i_char == osl_pkg::CH_TAB ||
                                 i_char == osl_pkg::CH_CR || i_char == osl_pkg::CH_LF) begin
                        // saturating line count
                        if (i_char == osl_pkg::CH_LF && !(&i_line)) begin
                            ln = i_line + 1'b1;
                        end
                    end else if (pu.hit) begin
                        res[cnt[0]] = mk_res(pu.kind, 8'd0, osl_pkg::ST_OK, w_line_out);
                        cnt = cnt + 2'd1;
                    end else if (op != osl_pkg::OP_NONE) begin
                        st.pend = op;
                        if (i_eos) begin
                            // flush the held operator at end of source
                            st.pend = osl_pkg::OP_NONE;
                            inf     = osl_pkg::op_info(op);
                            if (inf.lone) begin
                                res[cnt[0]] = mk_res(osl_pkg::K_LBRACK, 8'd0,
                                                     osl_pkg::ST_LONE_BAR, w_line_out);
                                st.mode = osl_pkg::MODE_HALT;
                            end else begin
                                res[cnt[0]] = mk_res(inf.single, 8'd0, osl_pkg::ST_OK,
                                                     w_line_out);
                            end
                            cnt = cnt + 2'd1;
                        end
                    end else begin
                        res[cnt[0]] = mk_res(osl_pkg::K_LBRACK, 8'd0,
                                             osl_pkg::ST_UNSUPPORTED, w_line_out);
                        cnt     = cnt + 2'd1;
                        st.mode = osl_pkg::MODE_HALT;
                    end
                end
            end
            default: begin
                st.mode = i_state.mode;
            end
        endcase

        if (i_eos) begin
            st.mode = osl_pkg::MODE_IDLE;
            st.pend = osl_pkg::OP_NONE;
        end

        if (cnt == 2'd2) begin
            res[1].last = 1'b1;
        end else if (cnt == 2'd1) begin
            res[0].last = 1'b1;
        end

        o_state = st;
        o_line  = ln;
        o_count = cnt;
        o_res   = res;
    end

endmodule

// ----- hdl/osl_result_queue.sv -----
// small result queue that takes up to two items per cycle and gives one while i_ready is high
`timescale 1ns / 1ps

module osl_result_queue (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [1:0]                  i_push_count,
    input  osl_pkg::t_result [1:0]      i_push_res,
    output logic                        o_room2,
    output logic                        o_valid,
    input  logic                        i_ready,
    output osl_pkg::t_result            o_res
);

    osl_pkg::t_result               r_mem [osl_pkg::QDEPTH];
    logic [osl_pkg::QPTR_W-1:0]     r_wp;
    logic [osl_pkg::QPTR_W-1:0]     r_rp;
    logic [osl_pkg::QCNT_W-1:0]     r_count;
    logic [osl_pkg::QPTR_W-1:0]     n_wp1;
    logic                           w_pop;

    assign w_pop   = o_valid && i_ready;
    assign o_valid = (r_count != '0);
    assign o_res   = r_mem[r_rp];
    assign o_room2 = (r_count <= osl_pkg::QCNT_W'(osl_pkg::QDEPTH - 2));
    assign n_wp1   = r_wp + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_push_count != 2'd0) begin
            r_mem[r_wp] <= i_push_res[0];
        end
        if (i_push_count == 2'd2) begin
            r_mem[n_wp1] <= i_push_res[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= r_wp + osl_pkg::QPTR_W'(i_push_count);
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_count <= r_count + osl_pkg::QCNT_W'(i_push_count)
                     - osl_pkg::QCNT_W'(w_pop);
        end
    end

endmodule

// ----- hdl/operator_string_lexer.sv -----
// top level of the operator and string lexer: input register, step logic, result queue
`timescale 1ns / 1ps
// a byte taken into the input register goes through the step logic into the result queue
// throughput: one byte per cycle when not stalled; two results leave the queue one by one
// the input stage waits only while the four-entry result queue lacks room for two items
// reset (synchronous, active low) clears mode, held operator, quote kind and line count
// and empties both the input register and the result queue

module operator_string_lexer #(
    parameter int LINE_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_char_in,
    input  logic        i_end_of_source,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [5:0]  o_token_kind,
    output logic [7:0]  o_string_byte,
    output logic [1:0]  o_status,
    output logic [15:0] o_line_number,
    output logic        o_last
);

    logic                   r_in_valid;
    logic [7:0]             r_in_char;
    logic                   r_in_eos;
    osl_pkg::t_lex_state    r_state;
    logic [LINE_BITS-1:0]   r_line;
    osl_pkg::t_lex_state    n_state;
    logic [LINE_BITS-1:0]   n_line;
    logic [1:0]             w_count;
    osl_pkg::t_result [1:0] w_res;
    logic [1:0]             w_push_count;
    logic                   w_room2;
    logic                   w_proc;
    osl_pkg::t_result       w_head;

    assign w_proc       = r_in_valid && w_room2;
    assign o_in_ready   = !r_in_valid || w_proc;
    assign w_push_count = w_proc ? w_count : 2'd0;

    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_in_char <= i_char_in;
            r_in_eos  <= i_end_of_source;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_state    <= '{mode: osl_pkg::MODE_IDLE, pend: osl_pkg::OP_NONE,
                            quote_single: 1'b0};
            r_line     <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_proc) begin
                r_state <= n_state;
                r_line  <= n_line;
            end
        end
    end

    osl_step #(
        .LINE_BITS (LINE_BITS)
    ) u_step (
        .i_state (r_state),
        .i_line  (r_line),
        .i_char  (r_in_char),
        .i_eos   (r_in_eos),
        .o_state (n_state),
        .o_line  (n_line),
        .o_count (w_count),
        .o_res   (w_res)
    );

    osl_result_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_count (w_push_count),
        .i_push_res   (w_res),
        .o_room2      (w_room2),
        .o_valid      (o_out_valid),
        .i_ready      (i_out_ready),
        .o_res        (w_head)
    );

    assign o_token_kind  = w_head.kind;
    assign o_string_byte = w_head.sbyte;
    assign o_status      = w_head.status;
    assign o_line_number = w_head.line;
    assign o_last        = w_head.last;

endmodule
